>>> design/lzd_pkg.sv
package lzd_pkg;

  // History window and copy limits
  localparam int WindowDepth = 4096;
  localparam int WinAw       = $clog2(WindowDepth);
  localparam int MaxCopy     = 18;

  // Token fields: 4-bit length code plus bias, 12-bit distance code plus one
  localparam int LenW       = 5;
  localparam int DistW      = 13;
  localparam int LenBias    = 3;
  localparam int SizeW      = 24;
  localparam int HdrLen     = 8;
  localparam int MagicLen   = 5;

  // Command queue between parser and executor
  localparam int CmdQDepth = 4;
  localparam int CmdQAw    = $clog2(CmdQDepth);

  typedef enum logic [2:0] {
    RK_DATA    = 3'd0,
    RK_DONE    = 3'd1,
    RK_BAD_HDR = 3'd2,
    RK_BAD_REF = 3'd3,
    RK_SHORT   = 3'd4
  } result_kind_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_ITEM,
    PH_TOKEN2,
    PH_DRAIN
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LIT,
    BK_RD,
    BK_CP,
    BK_STAT
  } bk_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    result_kind_e     result_kind;
    logic [SizeW-1:0] total_size;
    logic             run_last;
  } out_t;

  // At most one command per input byte: optional data work, then optional status
  typedef struct packed {
    logic             has_data;
    logic             is_copy;
    logic [7:0]       lit_byte;
    logic [LenW-1:0]  len;
    logic [DistW-1:0] distance;
    logic             has_status;
    result_kind_e     status;
    logic [SizeW-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // "LZ77" followed by the type byte
  function automatic logic [7:0] hdr_magic(logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'h4C;
      3'd1:    m = 8'h5A;
      3'd2:    m = 8'h37;
      3'd3:    m = 8'h37;
      3'd4:    m = 8'h10;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> design/lzd_ram.sv
module lzd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> design/lzd_front.sv
module lzd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lzd_pkg::in_t        in_i,
  output logic                push_o,
  output lzd_pkg::cmd_t       cmd_o
);

  lzd_pkg::phase_e              phase_q, phase_d;
  logic [2:0]                   hdr_idx_q, hdr_idx_d;
  logic [lzd_pkg::SizeW-1:0]    exp_q, exp_d;
  logic [lzd_pkg::SizeW-1:0]    prod_q, prod_d;
  logic [7:0]                   flag_bits_q, flag_bits_d;
  logic [3:0]                   flag_idx_q, flag_idx_d;
  logic [7:0]                   token_hi_q, token_hi_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lzd_pkg::PH_HEADER;
      hdr_idx_q   <= '0;
      exp_q       <= '0;
      prod_q      <= '0;
      flag_bits_q <= '0;
      flag_idx_q  <= 4'd8;
      token_hi_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      exp_q       <= exp_d;
      prod_q      <= prod_d;
      flag_bits_q <= flag_bits_d;
      flag_idx_q  <= flag_idx_d;
      token_hi_q  <= token_hi_d;
    end
  end

  logic [7:0]                  b;
  logic                        last;
  logic                        hdr_ok;
  logic [lzd_pkg::SizeW-1:0]   exp_new;
  logic [lzd_pkg::SizeW-1:0]   prod_new;
  logic [lzd_pkg::SizeW:0]     prod_plus_len;
  logic [lzd_pkg::LenW-1:0]    len;
  logic [lzd_pkg::DistW-1:0]   distance;
  logic [3:0]                  flag_idx_inc;
  logic                        bad_ref;
  logic                        restart;
  logic                        data_done;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;

  assign len  = lzd_pkg::LenW'(token_hi_q[7:4]) + lzd_pkg::LenW'(lzd_pkg::LenBias);
  assign distance = {1'b0, token_hi_q[3:0], b} + lzd_pkg::DistW'(1);
  assign prod_plus_len = {1'b0, prod_q} + (lzd_pkg::SizeW + 1)'(len);
  assign bad_ref = ({{(lzd_pkg::SizeW + 1 - lzd_pkg::DistW){1'b0}}, distance} >
                    {1'b0, prod_q})
                 || (distance > lzd_pkg::DistW'(lzd_pkg::WindowDepth))
                 || (len > lzd_pkg::LenW'(lzd_pkg::MaxCopy))
                 || (prod_plus_len > {1'b0, exp_q});
  assign flag_idx_inc = flag_idx_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    exp_d       = exp_q;
    prod_d      = prod_q;
    flag_bits_d = flag_bits_q;
    flag_idx_d  = flag_idx_q;
    token_hi_d  = token_hi_q;
    cmd_o       = '0;
    cmd_o.status = lzd_pkg::RK_DATA;
    restart     = 1'b0;
    hdr_ok      = 1'b1;
    exp_new     = exp_q;
    prod_new    = prod_q;
    data_done   = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        lzd_pkg::PH_HEADER: begin
          if (hdr_idx_q < 3'(lzd_pkg::MagicLen)) begin
            hdr_ok = (b == lzd_pkg::hdr_magic(hdr_idx_q));
          end
          unique case (hdr_idx_q)
            3'd5:    exp_new[7:0]   = b;
            3'd6:    exp_new[15:8]  = b;
            3'd7:    exp_new[23:16] = b;
            default: exp_new        = exp_q;
          endcase
          if (!hdr_ok || last) begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = lzd_pkg::RK_BAD_HDR;
            if (last) restart = 1'b1;
            else phase_d = lzd_pkg::PH_DRAIN;
          end else begin
            exp_d     = exp_new;
            hdr_idx_d = hdr_idx_q + 3'd1;
            if (hdr_idx_q == 3'(lzd_pkg::HdrLen - 1)) begin
              if (exp_new == '0) begin
                cmd_o.has_status = 1'b1;
                cmd_o.status     = lzd_pkg::RK_DONE;
                phase_d          = lzd_pkg::PH_DRAIN;
              end else begin
                phase_d = lzd_pkg::PH_FLAG;
              end
            end
          end
        end
        lzd_pkg::PH_FLAG: begin
          flag_bits_d = b;
          flag_idx_d  = '0;
          phase_d     = lzd_pkg::PH_ITEM;
          if (last) begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = lzd_pkg::RK_SHORT;
            cmd_o.size       = exp_q;
            restart          = 1'b1;
          end
        end
        lzd_pkg::PH_ITEM: begin
          if (!flag_bits_q[7]) begin
            cmd_o.has_data = 1'b1;
            cmd_o.lit_byte = b;
            prod_new       = prod_q + lzd_pkg::SizeW'(1);
            data_done      = 1'b1;
          end else begin
            token_hi_d = b;
            phase_d    = lzd_pkg::PH_TOKEN2;
            if (last) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = lzd_pkg::RK_SHORT;
              cmd_o.size       = exp_q;
              restart          = 1'b1;
            end
          end
        end
        lzd_pkg::PH_TOKEN2: begin
          if (bad_ref) begin
            cmd_o.has_status = 1'b1;
            cmd_o.status     = lzd_pkg::RK_BAD_REF;
            if (last) restart = 1'b1;
            else phase_d = lzd_pkg::PH_DRAIN;
          end else begin
            cmd_o.has_data = 1'b1;
            cmd_o.is_copy  = 1'b1;
            cmd_o.len      = len;
            cmd_o.distance = distance;
            prod_new       = prod_plus_len[lzd_pkg::SizeW-1:0];
            data_done      = 1'b1;
          end
        end
        lzd_pkg::PH_DRAIN: begin
          if (last) restart = 1'b1;
        end
        default: phase_d = lzd_pkg::PH_DRAIN;
      endcase

      // Flag advance and completion check after literal or copy
      if (data_done) begin
        prod_d      = prod_new;
        flag_bits_d = {flag_bits_q[6:0], 1'b0};
        flag_idx_d  = flag_idx_inc;
        phase_d     = (flag_idx_inc >= 4'd8) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_ITEM;
        if (prod_new == exp_q) begin
          cmd_o.has_status = 1'b1;
          cmd_o.status     = lzd_pkg::RK_DONE;
          cmd_o.size       = exp_q;
          if (last) restart = 1'b1;
          else phase_d = lzd_pkg::PH_DRAIN;
        end else if (last) begin
          cmd_o.has_status = 1'b1;
          cmd_o.status     = lzd_pkg::RK_SHORT;
          cmd_o.size       = exp_q;
          restart          = 1'b1;
        end
      end

      if (restart) begin
        phase_d     = lzd_pkg::PH_HEADER;
        hdr_idx_d   = '0;
        exp_d       = '0;
        prod_d      = '0;
        flag_bits_d = '0;
        flag_idx_d  = 4'd8;
        token_hi_d  = '0;
      end
    end
  end

  assign push_o = accept_i && (cmd_o.has_data || cmd_o.has_status);

endmodule

>>> design/lzd_cmd_fifo.sv
module lzd_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lzd_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output lzd_pkg::cmd_t       head_o,
  output lzd_pkg::q_status_t  status_o
);

  lzd_pkg::cmd_t                 mem_q [lzd_pkg::CmdQDepth];
  logic [lzd_pkg::CmdQAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [lzd_pkg::CmdQAw:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + lzd_pkg::CmdQAw'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + lzd_pkg::CmdQAw'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (lzd_pkg::CmdQAw + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (lzd_pkg::CmdQAw + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == (lzd_pkg::CmdQAw + 1)'(lzd_pkg::CmdQDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> design/lzd_back.sv
module lzd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzd_pkg::cmd_t       head_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzd_pkg::out_t       out_o
);

  lzd_pkg::bk_state_e          state_q, state_d;
  lzd_pkg::cmd_t               cmd_q, cmd_d;
  logic [lzd_pkg::LenW-1:0]    cnt_q, cnt_d;
  logic [lzd_pkg::WinAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic                        out_valid_q, out_valid_d;
  lzd_pkg::out_t               out_q, out_d;

  logic                        can_load;
  logic                        load;
  logic                        ram_we, ram_re;
  logic [7:0]                  ram_wdata, ram_rdata;
  logic [lzd_pkg::WinAw-1:0]   ram_raddr;

  assign can_load = !out_valid_q || !out_stall_i;

  lzd_ram #(
    .Width(8),
    .Depth(lzd_pkg::WindowDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzd_pkg::BK_IDLE;
      cnt_q       <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wr_ptr_q    <= wr_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzd_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          if (!head_i.has_data)    state_d = lzd_pkg::BK_STAT;
          else if (head_i.is_copy) state_d = lzd_pkg::BK_RD;
          else                     state_d = lzd_pkg::BK_LIT;
        end
      end
      lzd_pkg::BK_LIT: begin
        if (can_load) state_d = cmd_q.has_status ? lzd_pkg::BK_STAT : lzd_pkg::BK_IDLE;
      end
      lzd_pkg::BK_RD: state_d = lzd_pkg::BK_CP;
      lzd_pkg::BK_CP: begin
        if (can_load) begin
          if (cnt_q == lzd_pkg::LenW'(1)) begin
            state_d = cmd_q.has_status ? lzd_pkg::BK_STAT : lzd_pkg::BK_IDLE;
          end else begin
            state_d = lzd_pkg::BK_RD;
          end
        end
      end
      lzd_pkg::BK_STAT: begin
        if (can_load) state_d = lzd_pkg::BK_IDLE;
      end
      default: state_d = lzd_pkg::BK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop_o     = 1'b0;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    wr_ptr_d  = wr_ptr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = cmd_q.lit_byte;
    ram_raddr = wr_ptr_q - cmd_q.distance[lzd_pkg::WinAw-1:0];
    load      = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      lzd_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          cnt_d = head_i.len;
        end
      end
      lzd_pkg::BK_LIT: begin
        if (can_load) begin
          load     = 1'b1;
          ram_we   = 1'b1;
          wr_ptr_d = wr_ptr_q + lzd_pkg::WinAw'(1);
          out_d.out_byte    = cmd_q.lit_byte;
          out_d.result_kind = lzd_pkg::RK_DATA;
          out_d.total_size  = '0;
          out_d.run_last    = !cmd_q.has_status;
        end
      end
      lzd_pkg::BK_RD: ram_re = 1'b1;
      lzd_pkg::BK_CP: begin
        ram_wdata = ram_rdata;
        if (can_load) begin
          load     = 1'b1;
          ram_we   = 1'b1;
          wr_ptr_d = wr_ptr_q + lzd_pkg::WinAw'(1);
          cnt_d    = cnt_q - lzd_pkg::LenW'(1);
          out_d.out_byte    = ram_rdata;
          out_d.result_kind = lzd_pkg::RK_DATA;
          out_d.total_size  = '0;
          out_d.run_last    = (cnt_q == lzd_pkg::LenW'(1)) && !cmd_q.has_status;
        end
      end
      lzd_pkg::BK_STAT: begin
        if (can_load) begin
          load = 1'b1;
          out_d.out_byte    = '0;
          out_d.result_kind = cmd_q.status;
          out_d.total_size  = cmd_q.size;
          out_d.run_last    = 1'b1;
        end
      end
      default: load = 1'b0;
    endcase
    if (load)             out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/lz77_type10_stream_decompressor_top.sv
// Channel  Dir  Handshake                 Payload
// input    in   in_valid_i / in_stall_o   in_i  (lzd_pkg::in_t: in_byte, in_last)
// output   out  out_valid_o / out_stall_i out_o (lzd_pkg::out_t: out_byte, result_kind,
//                                                total_size, run_last)
//
// Executor: a command is taken off the queue first; a literal is then output, each copied
//   byte takes a history RAM read, then registered data out and write-back, and a status
//   result is output on its own. The executor serves one command at a time through its
//   single history read/write loop.
// Reset: rst_ni clears the parser (header phase, flag index eight), queue and executor.
//   The history RAM is not cleared; only bytes of the current stream are ever read.
// Stalls: in_stall_o is high while the command queue is full; out_stall_i holds the
//   output register and stops executor loads, the parser keeps going until the queue fills.
module lz77_type10_stream_decompressor_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzd_pkg::in_t       in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzd_pkg::out_t      out_o
);

  logic               accept;
  logic               push;
  logic               pop;
  lzd_pkg::cmd_t      cmd_push;
  lzd_pkg::cmd_t      cmd_head;
  lzd_pkg::q_status_t q_status;

  // A transaction on the input channel; every accepted byte is parsed at once
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_status.full;

  // Parser: header check, flag bits, token decode and reference checks
  lzd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (push),
    .cmd_o    (cmd_push)
  );

  // Command queue decoupling parser from executor
  lzd_cmd_fifo u_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_push),
    .pop_i    (pop),
    .head_o   (cmd_head),
    .status_o (q_status)
  );

  // Executor: literal and copy bytes through history RAM, then status
  lzd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .q_empty_i   (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Status results always close the run of results for their byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.result_kind != lzd_pkg::RK_DATA) |-> out_o.run_last)
    else $error("status result without run_last");

  // Data results carry no size
  a_data_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.result_kind == lzd_pkg::RK_DATA) |-> (out_o.total_size == '0))
    else $error("data result with nonzero size");

  // The queue only fills after a command was pushed
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(push))
    else $error("queue became full without a push");

endmodule

>>> dv/tb_top.sv
module tb_top;

  // "LZ77" plus the type byte, first byte in the top bits
  localparam logic [39:0] SIG_BYTES = 40'h4C5A373710;
  // Settling wait after the last expected result, with margin
  localparam int TAIL_CYCLES = 200;
  localparam int RAND_ITEMS_PER_PHASE = 75;

  // Damage applied to one generated stream
  typedef enum int {
    FLT_NONE,
    FLT_TRAIL,
    FLT_TRUNC,
    FLT_BADHDR,
    FLT_BADREF,
    FLT_NOISE
  } fault_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lzd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lzd_pkg::out_t out_data;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent = 0;
  int bad_count = 0;

  lzd_pkg::out_t pending_out[$];  // expected results, oldest first
  lzd_pkg::in_t  stream_q[$];     // compressed stream waiting to be sent

  // Decoder state mirrored on the testbench side
  logic [7:0]                win_mem [lzd_pkg::WindowDepth];
  logic [lzd_pkg::SizeW-1:0] made_cnt;
  logic [lzd_pkg::SizeW-1:0] decl_size;
  int                        hdr_pos;
  logic [7:0]                flag_reg;
  int                        flag_pos;
  logic [7:0]                tok_hi;
  lzd_pkg::phase_e           ph;

  always #5 clk_i = ~clk_i;

  lz77_type10_stream_decompressor_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Back to header phase with all counters cleared
  function automatic void clear_stream_state();
    made_cnt  = '0;
    decl_size = '0;
    hdr_pos   = 0;
    flag_reg  = '0;
    flag_pos  = 8;
    tok_hi    = '0;
    ph        = lzd_pkg::PH_HEADER;
  endfunction

  function automatic void push_result(logic [7:0] b, lzd_pkg::result_kind_e k,
                                      logic [lzd_pkg::SizeW-1:0] sz);
    lzd_pkg::out_t r;
    r.out_byte    = b;
    r.result_kind = k;
    r.total_size  = sz;
    r.run_last    = 1'b0;
    pending_out.push_back(r);
  endfunction

  // After a status: restart on a marked byte, otherwise skip to the mark
  function automatic void end_stream(logic last);
    if (last) begin
      clear_stream_state();
    end else begin
      ph = lzd_pkg::PH_DRAIN;
    end
  endfunction

  function automatic void put_data(logic [7:0] b);
    win_mem[made_cnt[lzd_pkg::WinAw-1:0]] = b;
    made_cnt = made_cnt + lzd_pkg::SizeW'(1);
    push_result(b, lzd_pkg::RK_DATA, '0);
  endfunction

  function automatic void next_flag();
    flag_reg = flag_reg << 1;
    flag_pos++;
    ph = (flag_pos >= 8) ? lzd_pkg::PH_FLAG : lzd_pkg::PH_ITEM;
  endfunction

  // Completion beats the end mark; an end mark before completion is a short stream
  function automatic void check_complete(logic last);
    if (made_cnt == decl_size) begin
      push_result('0, lzd_pkg::RK_DONE, decl_size);
      end_stream(last);
    end else if (last) begin
      push_result('0, lzd_pkg::RK_SHORT, decl_size);
      clear_stream_state();
    end
  endfunction

  // Expected results for one accepted stream byte
  function automatic void decode_byte(lzd_pkg::in_t item);
    int         before_n;
    int         len;
    int         distance;
    int         src;
    logic       ok;
    logic [7:0] b;
    logic       last;
    b        = item.in_byte;
    last     = item.in_last;
    before_n = pending_out.size();
    case (ph)
      lzd_pkg::PH_HEADER: begin
        ok = 1'b1;
        if (hdr_pos < lzd_pkg::MagicLen) begin
          ok = (b == SIG_BYTES[39-8*hdr_pos -: 8]);
        end else if (hdr_pos < lzd_pkg::HdrLen) begin
          decl_size = decl_size |
                      (lzd_pkg::SizeW'(b) << (8 * (hdr_pos - lzd_pkg::MagicLen)));
        end
        // a mark anywhere in the header, the 8th byte too, is a bad header
        if (!ok || last) begin
          push_result('0, lzd_pkg::RK_BAD_HDR, '0);
          end_stream(last);
        end else begin
          hdr_pos++;
          if (hdr_pos >= lzd_pkg::HdrLen) begin
            if (decl_size == '0) begin
              push_result('0, lzd_pkg::RK_DONE, '0);
              end_stream(1'b0);
            end else begin
              ph = lzd_pkg::PH_FLAG;
            end
          end
        end
      end
      lzd_pkg::PH_FLAG: begin
        flag_reg = b;
        flag_pos = 0;
        ph       = lzd_pkg::PH_ITEM;
        if (last) begin
          push_result('0, lzd_pkg::RK_SHORT, decl_size);
          clear_stream_state();
        end
      end
      lzd_pkg::PH_ITEM: begin
        if (!flag_reg[7]) begin
          put_data(b);
          next_flag();
          check_complete(last);
        end else begin
          tok_hi = b;
          ph     = lzd_pkg::PH_TOKEN2;
          if (last) begin
            push_result('0, lzd_pkg::RK_SHORT, decl_size);
            clear_stream_state();
          end
        end
      end
      lzd_pkg::PH_TOKEN2: begin
        len      = int'(tok_hi[7:4]) + lzd_pkg::LenBias;
        distance = int'({tok_hi[3:0], b}) + 1;
        if (distance > int'(made_cnt) || distance > lzd_pkg::WindowDepth ||
            len > lzd_pkg::MaxCopy || int'(made_cnt) + len > int'(decl_size)) begin
          push_result('0, lzd_pkg::RK_BAD_REF, '0);
          end_stream(last);
        end else begin
          // byte by byte, so an overlapping copy repeats what it just wrote
          for (int i = 0; i < len; i++) begin
            src = int'(made_cnt) - distance;
            put_data(win_mem[src[lzd_pkg::WinAw-1:0]]);
          end
          next_flag();
          check_complete(last);
        end
      end
      default: begin
        if (last) begin
          clear_stream_state();
        end
      end
    endcase
    if (pending_out.size() > before_n) begin
      pending_out[pending_out.size()-1].run_last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(string what, lzd_pkg::out_t want,
                                       lzd_pkg::out_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $write("%0t %0s: expected byte %02h kind %0d size %06h last %0b",
             $realtime, what, want.out_byte, want.result_kind, want.total_size,
             want.run_last);
      $display(", got byte %02h kind %0d size %06h last %0b",
               got.out_byte, got.result_kind, got.total_size, got.run_last);
    end
  endfunction

  // A result transaction completes at an edge with valid high and stall low; both
  // are read as they stood just before the edge.
  always @(posedge clk_i) begin
    lzd_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        log_mismatch("result with none expected", '0, out_data);
      end else begin
        want = pending_out.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.result_kind !== want.result_kind ||
            out_data.total_size !== want.total_size || out_data.run_last !== want.run_last) begin
          log_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] b, logic last);
    stream_q.push_back({b, last});
  endfunction

  // Offers one byte, with random idle cycles first. Valid stays high after the
  // transaction; the next call either lowers it or replaces the payload, once per step.
  task automatic send_item(lzd_pkg::in_t item);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    decode_byte(item);
    items_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[k]) begin
      send_item(stream_q[k]);
    end
    stream_q.delete();
  endtask

  // Sender holds off until every expected result is out, then lets the block settle
  task automatic settle_out();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Builds one stream of the given declared size. Literals and copies are mixed at
  // random; copies stay legal unless the fault asks for a bad one.
  function automatic void build_stream(int size, fault_e fault);
    int          n_out;
    int          flag_at;
    int          room;
    int          len;
    int          distance;
    int          cut;
    int          bad_at;
    logic [7:0]  flags;
    logic [11:0] dcode;
    logic        broken;
    logic [23:0] sz;
    stream_q.delete();
    if (fault == FLT_NOISE) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom), 1'b0);
    end else begin
      sz = 24'(size);
      for (int k = 0; k < lzd_pkg::MagicLen; k++) begin
        add_byte(SIG_BYTES[39-8*k -: 8], 1'b0);
      end
      add_byte(sz[7:0], 1'b0);
      add_byte(sz[15:8], 1'b0);
      add_byte(sz[23:16], 1'b0);
      if (fault == FLT_BADHDR) begin
        cut = $urandom_range(lzd_pkg::MagicLen - 1);
        stream_q[cut].in_byte = stream_q[cut].in_byte ^ 8'($urandom_range(255, 1));
      end
      n_out  = 0;
      broken = 1'b0;
      bad_at = (size > 0) ? $urandom_range(size - 1) : 0;
      while (n_out < size && !broken) begin
        flag_at = stream_q.size();
        add_byte('0, 1'b0);
        flags = '0;
        for (int k = 7; k >= 0 && n_out < size && !broken; k--) begin
          room = size - n_out;
          if (fault == FLT_BADREF && n_out >= bad_at) begin
            // either runs past the declared size or reaches before the stream start
            flags[k] = 1'b1;
            if (room < lzd_pkg::MaxCopy && n_out > 0 && $urandom_range(1)) begin
              len      = $urandom_range(lzd_pkg::MaxCopy, room + 1);
              distance = $urandom_range(n_out, 1);
            end else begin
              len      = $urandom_range(lzd_pkg::MaxCopy, lzd_pkg::LenBias);
              distance = $urandom_range(lzd_pkg::WindowDepth, n_out + 1);
            end
            dcode = 12'(distance - 1);
            add_byte({4'(len - lzd_pkg::LenBias), dcode[11:8]}, 1'b0);
            add_byte(dcode[7:0], 1'b0);
            broken = 1'b1;
          end else if (n_out > 0 && room >= lzd_pkg::LenBias && $urandom_range(2) != 0) begin
            flags[k] = 1'b1;
            len = $urandom_range((room < lzd_pkg::MaxCopy) ? room : lzd_pkg::MaxCopy,
                                 lzd_pkg::LenBias);
            // short distances most of the time, so copies overlap often
            distance = $urandom_range(($urandom_range(3) == 0) ? n_out :
                                      ((n_out < 8) ? n_out : 8), 1);
            dcode = 12'(distance - 1);
            add_byte({4'(len - lzd_pkg::LenBias), dcode[11:8]}, 1'b0);
            add_byte(dcode[7:0], 1'b0);
            n_out += len;
          end else begin
            add_byte(8'($urandom), 1'b0);
            n_out++;
          end
        end
        stream_q[flag_at].in_byte = flags;
      end
      case (fault)
        FLT_TRAIL:  repeat ($urandom_range(3, 1)) add_byte(8'($urandom), 1'b0);
        FLT_BADREF: repeat ($urandom_range(3)) add_byte(8'($urandom), 1'b0);
        FLT_TRUNC: begin
          cut = $urandom_range(stream_q.size() - 1);
          while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
        end
        default: ;
      endcase
    end
    stream_q[stream_q.size()-1].in_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Wrong first byte, then one drained byte carrying the end mark
  task automatic test_bad_magic();
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    send_stream();
  endtask

  // Declared size zero: done right after the header, the rest is drained
  task automatic test_empty_stream();
    for (int k = 0; k < lzd_pkg::MagicLen; k++) begin
      add_byte(SIG_BYTES[39-8*k -: 8], 1'b0);
    end
    repeat (3) add_byte(8'h00, 1'b0);
    add_byte(8'hAA, 1'b1);
    send_stream();
  endtask

  // Largest declared size; literal, distance-one copy that repeats it, literal with
  // the end mark, so the stream ends short
  task automatic test_overlap_short();
    for (int k = 0; k < lzd_pkg::MagicLen; k++) begin
      add_byte(SIG_BYTES[39-8*k -: 8], 1'b0);
    end
    repeat (3) add_byte(8'hFF, 1'b0);
    add_byte(8'h40, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    send_stream();
    settle_out();
  endtask

  // Mostly well-formed streams with random content, the rest damaged or noise
  task automatic test_random_streams(int idle_pct, int stall_pct, int n_items);
    int     start;
    int     r;
    int     size;
    fault_e fault;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 55)      fault = FLT_NONE;
      else if (r < 65) fault = FLT_TRAIL;
      else if (r < 77) fault = FLT_TRUNC;
      else if (r < 84) fault = FLT_BADHDR;
      else if (r < 94) fault = FLT_BADREF;
      else             fault = FLT_NOISE;
      r = $urandom_range(99);
      if (r < 5)       size = 0;
      else if (r < 85) size = $urandom_range(40, 1);
      else             size = $urandom_range(200, 41);
      build_stream(size, fault);
      send_stream();
    end
    settle_out();
  endtask

  initial begin
    clear_stream_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_magic();
    test_empty_stream();
    test_overlap_short();
    test_random_streams(0, 0, RAND_ITEMS_PER_PHASE);
    test_random_streams(66, 0, RAND_ITEMS_PER_PHASE);
    test_random_streams(0, 66, RAND_ITEMS_PER_PHASE);
    test_random_streams(26, 26, RAND_ITEMS_PER_PHASE);
    if (bad_count == 0) begin
      $display("PASS lz77_type10_stream_decompressor_top");
    end else begin
      $display("FAIL lz77_type10_stream_decompressor_top");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAIL lz77_type10_stream_decompressor_top");
    $finish;
  end

endmodule
